FILE: rtl/tss_pkg.sv
package tss_pkg;

   // Field widths of the command and result words.
   localparam int HANDLE_W = 16;
   localparam int VALUE_W  = 32;
   localparam int KIND_W   = 3;
   localparam int SUSP_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;

   // Event kinds reported on the result channel.
   localparam logic [KIND_W-1:0] EV_SELF_SWITCH = 3'd0;
   localparam logic [KIND_W-1:0] EV_TABLE_FULL  = 3'd1;
   localparam logic [KIND_W-1:0] EV_SWITCH_CNT  = 3'd2;
   localparam logic [KIND_W-1:0] EV_SUSP_NOTICE = 3'd3;
   localparam logic [KIND_W-1:0] EV_SUSP_ALARM  = 3'd4;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SWITCH_THR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SUSP_THR   = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [VALUE_W-1:0] SWITCH_THR_RESET = 32'hFFFF_FFF0;
   localparam logic [SUSP_W-1:0]  SUSP_THR_RESET   = 8'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;
      logic enroll_first;
      logic resolve;
      logic emit_alarm;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic alarm_pending;
   } status_type;

endpackage

FILE: rtl/tss_ctrl.sv
module tss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  tss_pkg::status_type status,
   output tss_pkg::cmd_type    cmd
);
   import tss_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_LOOK1 = 2'd1;
   localparam logic [1:0] ST_LOOK2 = 2'd2;
   localparam logic [1:0] ST_EMIT2 = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Sequence: enroll the first handle, resolve the event, then an optional alarm word.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start) state_in = ST_LOOK1;
         ST_LOOK1: state_in = ST_LOOK2;
         ST_LOOK2: state_in = status.alarm_pending ? ST_EMIT2 : ST_IDLE;
         ST_EMIT2: state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands are decoded straight from the state; latch also needs start.
   assign busy             = (state_ff != ST_IDLE);
   assign cmd.latch        = (state_ff == ST_IDLE) && start;
   assign cmd.enroll_first = (state_ff == ST_LOOK1);
   assign cmd.resolve      = (state_ff == ST_LOOK2);
   assign cmd.emit_alarm   = (state_ff == ST_EMIT2);

endmodule

FILE: rtl/tss_dpath.sv
module tss_dpath #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tss_pkg::cmd_type                   cmd,
   output tss_pkg::status_type                status,
   input  logic                               req_mode,
   input  logic [tss_pkg::HANDLE_W-1:0]       req_first_task,
   input  logic [tss_pkg::HANDLE_W-1:0]       req_second_task,
   input  logic [tss_pkg::HANDLE_W-1:0]       req_task_number,
   input  logic                               csr_write,
   input  logic [tss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                               rsp_valid,
   output logic [tss_pkg::KIND_W-1:0]         rsp_event_kind,
   output logic                               rsp_is_alarm,
   output logic [tss_pkg::VALUE_W-1:0]        rsp_event_value,
   output logic [tss_pkg::HANDLE_W-1:0]       rsp_event_task,
   output logic                               rsp_quarantine,
   output logic [tss_pkg::HANDLE_W-1:0]       rsp_quarantine_task,
   output logic                               rsp_last
);
   import tss_pkg::*;

   localparam int OCC_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   // Configuration registers.
   logic [VALUE_W-1:0] switch_thr_ff;
   logic [SUSP_W-1:0]  susp_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         switch_thr_ff <= SWITCH_THR_RESET;
         susp_thr_ff   <= SUSP_THR_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_SWITCH_THR: switch_thr_ff <= csr_data;
            CSR_SUSP_THR:   susp_thr_ff   <= csr_data[SUSP_W-1:0];
            default:        ;
         endcase
      end
   end

   // Command word held for the length of the event.
   logic                mode_ff;
   logic [HANDLE_W-1:0] first_ff;
   logic [HANDLE_W-1:0] second_ff;
   logic [HANDLE_W-1:0] number_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff   <= req_mode;
         first_ff  <= req_first_task;
         second_ff <= req_second_task;
         number_ff <= req_task_number;
      end
   end

   // Task table in flip-flops; only entries below the occupancy are ever read.
   logic [HANDLE_W-1:0] handle_ff [TABLE_ENTRIES];
   logic [VALUE_W-1:0]  sw_cnt_ff [TABLE_ENTRIES];
   logic [SUSP_W-1:0]   su_cnt_ff [TABLE_ENTRIES];
   logic [OCC_W-1:0]    occ_ff;

   logic                     self_switch;
   logic                     count_op;
   logic [HANDLE_W-1:0]      key;
   logic [TABLE_ENTRIES-1:0] hit_vec;
   logic [TABLE_ENTRIES-1:0] new_vec;
   logic                     hit;
   logic                     room;
   logic                     tgt_ok;
   logic [VALUE_W-1:0]       base_sw;
   logic [SUSP_W-1:0]        base_su;
   logic [VALUE_W-1:0]       sw_new;
   logic [SUSP_W-1:0]        su_new;
   logic                     sw_fire;
   logic                     su_fire;
   logic                     wr_any;
   logic [VALUE_W-1:0]       wr_sw;
   logic [SUSP_W-1:0]        wr_su;

   assign self_switch = !mode_ff && (first_ff == second_ff);
   assign count_op    = mode_ff || !self_switch;

   // Shared match unit: the first handle while enrolling, the event target afterwards.
   assign key  = (cmd.resolve && !mode_ff) ? second_ff : first_ff;
   assign room = (occ_ff < OCC_W'(TABLE_ENTRIES));

   always_comb begin
      hit_vec = '0;
      new_vec = '0;
      base_sw = '0;
      base_su = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         hit_vec[i] = (OCC_W'(i) < occ_ff) && (handle_ff[i] == key);
         new_vec[i] = room && (IDX_W'(i) == occ_ff[IDX_W-1:0]);
         if (hit_vec[i]) begin
            base_sw = base_sw | sw_cnt_ff[i];
            base_su = base_su | su_cnt_ff[i];
         end
      end
   end

   assign hit    = |hit_vec;
   assign tgt_ok = hit || room;

   // Counter update; a new entry starts from zero.
   assign sw_new  = base_sw + VALUE_W'(1);
   assign su_new  = base_su + SUSP_W'(1);
   assign sw_fire = (sw_new >= switch_thr_ff);
   assign su_fire = (su_new >= susp_thr_ff);

   assign status.alarm_pending = mode_ff && tgt_ok && su_fire;

   // Entry write: enrollment of the first handle, or the counted event.
   always_comb begin
      wr_any = 1'b0;
      wr_sw  = '0;
      wr_su  = '0;
      if (cmd.enroll_first) begin
         wr_any = !hit && room;
      end else if (cmd.resolve && count_op) begin
         wr_any = tgt_ok;
         if (mode_ff) begin
            wr_sw = base_sw;
            wr_su = su_fire ? '0 : su_new;
         end else begin
            wr_sw = sw_fire ? '0 : sw_new;
            wr_su = base_su;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (wr_any && (hit ? hit_vec[i] : new_vec[i])) begin
            handle_ff[i] <= key;
            sw_cnt_ff[i] <= wr_sw;
            su_cnt_ff[i] <= wr_su;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else if (wr_any && !hit) begin
         occ_ff <= occ_ff + OCC_W'(1);
      end
   end

   // Result word register.
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [KIND_W-1:0]   kind_ff;
   logic [KIND_W-1:0]   kind_in;
   logic                alarm_ff;
   logic                alarm_in;
   logic [VALUE_W-1:0]  value_ff;
   logic [VALUE_W-1:0]  value_in;
   logic [HANDLE_W-1:0] task_ff;
   logic [HANDLE_W-1:0] task_in;
   logic                quar_ff;
   logic                quar_in;
   logic [HANDLE_W-1:0] qtask_ff;
   logic [HANDLE_W-1:0] qtask_in;
   logic                last_ff;
   logic                last_in;
   logic [SUSP_W-1:0]   susp_hold_ff;

   always_comb begin
      rsp_valid_in = 1'b0;
      kind_in      = kind_ff;
      alarm_in     = alarm_ff;
      value_in     = value_ff;
      task_in      = task_ff;
      quar_in      = 1'b0;
      qtask_in     = '0;
      last_in      = 1'b1;
      if (cmd.emit_alarm) begin
         rsp_valid_in = 1'b1;
         kind_in      = EV_SUSP_ALARM;
         alarm_in     = 1'b1;
         value_in     = VALUE_W'(susp_hold_ff);
         task_in      = number_ff;
         quar_in      = 1'b1;
         qtask_in     = first_ff;
      end else if (cmd.resolve) begin
         if (mode_ff) begin
            rsp_valid_in = tgt_ok;
            kind_in      = EV_SUSP_NOTICE;
            alarm_in     = 1'b0;
            value_in     = VALUE_W'(su_new);
            task_in      = number_ff;
            last_in      = !su_fire;
         end else if (self_switch) begin
            rsp_valid_in = 1'b1;
            kind_in      = EV_SELF_SWITCH;
            alarm_in     = 1'b1;
            value_in     = VALUE_W'(second_ff);
            task_in      = second_ff;
            quar_in      = 1'b1;
            qtask_in     = second_ff;
         end else if (!tgt_ok) begin
            rsp_valid_in = 1'b1;
            kind_in      = EV_TABLE_FULL;
            alarm_in     = 1'b1;
            value_in     = VALUE_W'(occ_ff);
            task_in      = second_ff;
         end else begin
            rsp_valid_in = sw_fire;
            kind_in      = EV_SWITCH_CNT;
            alarm_in     = 1'b1;
            value_in     = sw_new;
            task_in      = second_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      alarm_ff <= alarm_in;
      value_ff <= value_in;
      task_ff  <= task_in;
      quar_ff  <= quar_in;
      qtask_ff <= qtask_in;
      last_ff  <= last_in;
      if (cmd.resolve) begin
         susp_hold_ff <= su_new;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_event_kind      = kind_ff;
   assign rsp_is_alarm        = alarm_ff;
   assign rsp_event_value     = value_ff;
   assign rsp_event_task      = task_ff;
   assign rsp_quarantine      = quar_ff;
   assign rsp_quarantine_task = qtask_ff;
   assign rsp_last            = last_ff;

endmodule

FILE: rtl/task_switch_supervisor_core.sv
// Task switch supervisor. A command word is taken when start is high and busy is
// low; busy stays high while the word is processed. An event with one or no
// result word passes the idle state in which the word is taken, then makes two
// passes through the single shared handle match unit (one to enroll the outgoing
// or suspected handle, one to resolve the event target); a suspicion report that
// reaches its threshold then passes a further state for its second result word.
// Result words appear on the rsp_ ports for one cycle each, marked by rsp_valid,
// with rsp_last on the final word of an event; the receiver cannot stall them, so
// it must take each word in the cycle it is shown. Thresholds may be written only
// while the block is idle.
module task_switch_supervisor_core #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_mode,
   input  logic [tss_pkg::HANDLE_W-1:0]       req_first_task,
   input  logic [tss_pkg::HANDLE_W-1:0]       req_second_task,
   input  logic [tss_pkg::HANDLE_W-1:0]       req_task_number,
   input  logic                               csr_write,
   input  logic [tss_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tss_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic                               rsp_valid,
   output logic [tss_pkg::KIND_W-1:0]         rsp_event_kind,
   output logic                               rsp_is_alarm,
   output logic [tss_pkg::VALUE_W-1:0]        rsp_event_value,
   output logic [tss_pkg::HANDLE_W-1:0]       rsp_event_task,
   output logic                               rsp_quarantine,
   output logic [tss_pkg::HANDLE_W-1:0]       rsp_quarantine_task,
   output logic                               rsp_last
);
   import tss_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencer.
   tss_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // Task table, counters and result register.
   tss_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_mode),
      .req_first_task      (req_first_task),
      .req_second_task     (req_second_task),
      .req_task_number     (req_task_number),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_event_kind      (rsp_event_kind),
      .rsp_is_alarm        (rsp_is_alarm),
      .rsp_event_value     (rsp_event_value),
      .rsp_event_task      (rsp_event_task),
      .rsp_quarantine      (rsp_quarantine),
      .rsp_quarantine_task (rsp_quarantine_task),
      .rsp_last            (rsp_last)
   );

endmodule

FILE: rtl/tss_checker.sv
module tss_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [tss_pkg::KIND_W-1:0]    rsp_event_kind,
   input logic                          rsp_is_alarm,
   input logic [tss_pkg::HANDLE_W-1:0]  rsp_event_task,
   input logic                          rsp_quarantine,
   input logic [tss_pkg::HANDLE_W-1:0]  rsp_quarantine_task,
   input logic                          rsp_last
);
   import tss_pkg::*;

   // After reset the block is idle and shows no word.
   a_reset_idle: assert property (@(posedge clock) reset |=> !busy && !rsp_valid)
      else $error("block not idle after reset");

   // An accepted command makes the block busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepting a command");

   // A word without last is followed at once by the rest of its event.
   a_second_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=> rsp_valid && rsp_last &&
         (rsp_event_kind == EV_SUSP_ALARM))
      else $error("missing second word of a suspicion event");

   // A quarantine order only comes with alarm severity.
   a_quar_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_quarantine) |-> rsp_is_alarm)
      else $error("quarantine order without alarm");

   // A self switch quarantines the very task it names.
   a_self_quar: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_kind == EV_SELF_SWITCH)) |->
         rsp_quarantine && (rsp_quarantine_task == rsp_event_task))
      else $error("self switch without matching quarantine");

endmodule

bind task_switch_supervisor_core tss_checker u_tss_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .rsp_valid           (rsp_valid),
   .rsp_event_kind      (rsp_event_kind),
   .rsp_is_alarm        (rsp_is_alarm),
   .rsp_event_task      (rsp_event_task),
   .rsp_quarantine      (rsp_quarantine),
   .rsp_quarantine_task (rsp_quarantine_task),
   .rsp_last            (rsp_last)
);
